[design/wpid_pkg.sv]
package wpid_pkg;

  // window of error*step products
  localparam int unsigned WINDOW_LEN = 16;
  localparam int unsigned HEAD_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  localparam int unsigned ERR_W   = 16;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned DRIVE_W = 32;

  // signed error * unsigned step
  localparam int unsigned PROD_W = ERR_W + STEP_W + 1;
  localparam int unsigned AREA_W = PROD_W + 1 + $clog2(WINDOW_LEN);

  // bit-serial multiplier: multiplicand MC_W bits two's complement,
  // multiplier MB_W bits two's complement with a magnitude of MAG_W bits
  localparam int unsigned MC_W   = AREA_W;
  localparam int unsigned MB_W   = 17;
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned MP_W   = MC_W + MAG_W;
  localparam int unsigned MCNT_W = $clog2(MAG_W);

  // derivative: |gain * difference| < 2^31, scaled by 2^16 before dividing
  localparam int unsigned GD_W   = 31;
  localparam int unsigned DIVD_W = GD_W + FRAC_W;
  localparam int unsigned DCNT_W = $clog2(DIVD_W);

  localparam int unsigned SUM_W = ((DIVD_W > MC_W) ? DIVD_W : MC_W) + 2;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_AREA,
    ST_LOAD,
    ST_DIV,
    ST_SUM_PI,
    ST_SUM_D,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [ERR_W-1:0] error_value;
    logic [STEP_W-1:0]       delta_time;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_value;
    logic                      saturated;
    logic                      zero_step;
  } out_item_t;

endpackage

[design/wpid_ram.sv]
module wpid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/wpid_smul.sv]
module wpid_smul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wpid_pkg::MC_W-1:0] a_i,
  input  logic [wpid_pkg::MB_W-1:0] b_i,
  output logic                      busy_o,
  output logic [wpid_pkg::MP_W-1:0] mag_o,
  output logic                      neg_o
);

  logic [wpid_pkg::MC_W-1:0]   a_abs;
  logic [wpid_pkg::MB_W-1:0]   b_abs;
  logic [wpid_pkg::MC_W-1:0]   a_q;
  logic [wpid_pkg::MAG_W-1:0]  b_q, b_d;
  logic [wpid_pkg::MC_W-1:0]   hi_q, hi_d;
  logic [wpid_pkg::MAG_W-1:0]  lo_q, lo_d;
  logic                        neg_q;
  logic [wpid_pkg::MC_W:0]     acc_sum;
  logic [wpid_pkg::MCNT_W-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;

  assign a_abs = a_i[wpid_pkg::MC_W-1] ? (~a_i + wpid_pkg::MC_W'(1)) : a_i;
  assign b_abs = b_i[wpid_pkg::MB_W-1] ? (~b_i + wpid_pkg::MB_W'(1)) : b_i;

  // add the multiplicand into the upper half, then shift one bit down
  assign acc_sum = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = '0;
      b_d    = b_abs[wpid_pkg::MAG_W-1:0];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = acc_sum[wpid_pkg::MC_W:1];
      lo_d  = {acc_sum[0], lo_q[wpid_pkg::MAG_W-1:1]};
      b_d   = b_q >> 1;
      cnt_d = cnt_q + wpid_pkg::MCNT_W'(1);
      if (cnt_q == wpid_pkg::MCNT_W'(wpid_pkg::MAG_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_abs;
      neg_q <= a_i[wpid_pkg::MC_W-1] ^ b_i[wpid_pkg::MB_W-1];
    end
    hi_q <= hi_d;
    lo_q <= lo_d;
    b_q  <= b_d;
  end

  assign busy_o = busy_q;
  assign mag_o  = {hi_q, lo_q};
  assign neg_o  = neg_q;

endmodule

[design/wpid_sdiv.sv]
module wpid_sdiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wpid_pkg::DIVD_W-1:0] dividend_i,
  input  logic [wpid_pkg::STEP_W-1:0] divisor_i,
  output logic                        busy_o,
  output logic [wpid_pkg::DIVD_W-1:0] quot_o
);

  logic [wpid_pkg::DIVD_W-1:0] q_q, q_d;
  logic [wpid_pkg::STEP_W-1:0] rem_q, rem_d;
  logic [wpid_pkg::STEP_W-1:0] d_q;
  logic [wpid_pkg::STEP_W:0]   trial, trial_sub;
  logic                        fits;
  logic [wpid_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;

  // restoring division, one quotient bit per cycle, MSB first
  assign trial     = {rem_q, q_q[wpid_pkg::DIVD_W-1]};
  assign fits      = trial >= {1'b0, d_q};
  assign trial_sub = trial - {1'b0, d_q};

  always_comb begin
    q_d    = q_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      q_d    = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial_sub[wpid_pkg::STEP_W-1:0] : trial[wpid_pkg::STEP_W-1:0];
      q_d   = {q_q[wpid_pkg::DIVD_W-2:0], fits};
      cnt_d = cnt_q + wpid_pkg::DCNT_W'(1);
      if (cnt_q == wpid_pkg::DCNT_W'(wpid_pkg::DIVD_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q <= divisor_i;
    end
    q_q   <= q_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;

endmodule

[design/windowed_pid_controller.sv]
// PID controller with a windowed integral. Each input beat (error sample, time step) gives
// one output beat: P + I + D in signed Q16.16, saturated to 32 bits, with flags for clipping
// and for a zero time step (D forced to 0). The integral is the exact sum of error*step over
// the last WINDOW_LEN samples, kept as products in a small RAM with one valid bit per entry,
// so the window reads as zeros after reset without any clearing pass. An item is accepted
// only in the idle state, so a new beat is not taken until the last result sits in the
// output register. Each item runs the three bit-serial multipliers side by side (error*step,
// P gain, D gain times the error difference), then the bit-serial derivative divider, one
// quotient bit per cycle, which overlaps the integral multiply, then sequencing and summing.
// A zero time step skips the divider. The output register lets the next item start while a
// result waits to be taken; if that result is still waiting when the next one is ready, the
// sequencer holds until the output is taken. The user must write gains over the APB port
// only while the block is idle; the block itself does not enforce this. A controller reset
// is the block reset.
module windowed_pid_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  wpid_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output wpid_pkg::out_item_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wpid_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [wpid_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [wpid_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // configuration
  logic [wpid_pkg::GAIN_W-1:0] prop_q, integ_q, deriv_q;
  logic                        cfg_wr;
  wpid_pkg::reg_idx_e          cfg_idx;

  // sequencer
  wpid_pkg::state_e state_q, state_d;
  logic in_ready, mul_start, area_upd, load_start, sum_pi, sum_d, out_load;
  logic in_fire;

  // window state
  logic [wpid_pkg::HEAD_W-1:0]     head_q, slot;
  logic [wpid_pkg::WINDOW_LEN-1:0] win_valid_q;
  logic [wpid_pkg::AREA_W-1:0]     area_q;
  logic [wpid_pkg::ERR_W-1:0]      prev_err_q;
  logic [wpid_pkg::STEP_W-1:0]     step_q;
  logic [wpid_pkg::PROD_W-1:0]     ram_rdata, evict, prod;
  logic [wpid_pkg::PROD_W-2:0]     prod_mag;

  // arithmetic units
  logic [wpid_pkg::MC_W-1:0] a0, a1, a2;
  logic [wpid_pkg::MB_W-1:0] b0, b1, b2;
  logic [2:0]                mul_busy;
  logic [wpid_pkg::MP_W-1:0] mag0, mag1, mag2;
  logic [2:0]                mul_neg;
  logic                      div_start, div_busy;
  logic [wpid_pkg::DIVD_W-1:0] quot;
  logic [wpid_pkg::ERR_W:0]    diff_in;

  // terms and sum
  logic [wpid_pkg::DRIVE_W-1:0] p_q;
  logic [wpid_pkg::DRIVE_W-2:0] p_mag;
  logic [wpid_pkg::SUM_W-1:0]   sum_q, i_ext, i_term, d_ext, d_term;
  logic                         zero_step;
  logic [wpid_pkg::SUM_W-wpid_pkg::DRIVE_W:0] sum_hi;
  logic                         sum_fits;

  // output register
  wpid_pkg::out_item_t out_q;
  logic                out_valid_q;

  //--------------------------------------------------------------------------
  // APB configuration port
  //--------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = wpid_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q  <= '0;
      integ_q <= '0;
      deriv_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wpid_pkg::REG_PROP_GAIN:  prop_q  <= pwdata[wpid_pkg::GAIN_W-1:0];
        wpid_pkg::REG_INTEG_GAIN: integ_q <= pwdata[wpid_pkg::GAIN_W-1:0];
        wpid_pkg::REG_DERIV_GAIN: deriv_q <= pwdata[wpid_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      wpid_pkg::REG_PROP_GAIN:
        prdata = {{(wpid_pkg::APB_DATA_W-wpid_pkg::GAIN_W){prop_q[wpid_pkg::GAIN_W-1]}}, prop_q};
      wpid_pkg::REG_INTEG_GAIN:
        prdata = {{(wpid_pkg::APB_DATA_W-wpid_pkg::GAIN_W){integ_q[wpid_pkg::GAIN_W-1]}},
                  integ_q};
      wpid_pkg::REG_DERIV_GAIN:
        prdata = {{(wpid_pkg::APB_DATA_W-wpid_pkg::GAIN_W){deriv_q[wpid_pkg::GAIN_W-1]}},
                  deriv_q};
      default:
        prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // Sequencer
  //--------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wpid_pkg::ST_IDLE:   if (in_valid_i) state_d = wpid_pkg::ST_MUL;
      wpid_pkg::ST_MUL:    if (mul_busy == 3'b000) state_d = wpid_pkg::ST_AREA;
      wpid_pkg::ST_AREA:   state_d = wpid_pkg::ST_LOAD;
      wpid_pkg::ST_LOAD:   state_d = wpid_pkg::ST_DIV;
      wpid_pkg::ST_DIV:    if (!mul_busy[0] && !div_busy) state_d = wpid_pkg::ST_SUM_PI;
      wpid_pkg::ST_SUM_PI: state_d = wpid_pkg::ST_SUM_D;
      wpid_pkg::ST_SUM_D:  state_d = wpid_pkg::ST_DONE;
      wpid_pkg::ST_DONE:   if (!out_valid_q || out_ready_i) state_d = wpid_pkg::ST_IDLE;
      default:             state_d = wpid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    area_upd   = 1'b0;
    load_start = 1'b0;
    sum_pi     = 1'b0;
    sum_d      = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      wpid_pkg::ST_IDLE:   in_ready   = 1'b1;
      wpid_pkg::ST_AREA:   area_upd   = 1'b1;
      wpid_pkg::ST_LOAD:   load_start = 1'b1;
      wpid_pkg::ST_SUM_PI: sum_pi     = 1'b1;
      wpid_pkg::ST_SUM_D:  sum_d      = 1'b1;
      wpid_pkg::ST_DONE:   out_load   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_fire   = in_valid_i & in_ready;
  assign mul_start = in_fire;
  assign div_start = load_start & ~zero_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wpid_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  //--------------------------------------------------------------------------
  // Multipliers and divider
  //--------------------------------------------------------------------------
  assign diff_in = {in_data_i.error_value[wpid_pkg::ERR_W-1], in_data_i.error_value}
                 - {prev_err_q[wpid_pkg::ERR_W-1], prev_err_q};

  // unit 0 forms error*step first, then integ_gain * area
  assign a0 = load_start ? area_q
            : {{(wpid_pkg::MC_W-wpid_pkg::ERR_W){in_data_i.error_value[wpid_pkg::ERR_W-1]}},
               in_data_i.error_value};
  assign b0 = load_start
            ? {{(wpid_pkg::MB_W-wpid_pkg::GAIN_W){integ_q[wpid_pkg::GAIN_W-1]}}, integ_q}
            : {{(wpid_pkg::MB_W-wpid_pkg::STEP_W){1'b0}}, in_data_i.delta_time};

  assign a1 = {{(wpid_pkg::MC_W-wpid_pkg::ERR_W){in_data_i.error_value[wpid_pkg::ERR_W-1]}},
               in_data_i.error_value};
  assign b1 = {{(wpid_pkg::MB_W-wpid_pkg::GAIN_W){prop_q[wpid_pkg::GAIN_W-1]}}, prop_q};

  assign a2 = {{(wpid_pkg::MC_W-wpid_pkg::ERR_W-1){diff_in[wpid_pkg::ERR_W]}}, diff_in};
  assign b2 = {{(wpid_pkg::MB_W-wpid_pkg::GAIN_W){deriv_q[wpid_pkg::GAIN_W-1]}}, deriv_q};

  wpid_smul u_mul_area (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start | load_start),
    .a_i     (a0),
    .b_i     (b0),
    .busy_o  (mul_busy[0]),
    .mag_o   (mag0),
    .neg_o   (mul_neg[0])
  );

  wpid_smul u_mul_prop (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (a1),
    .b_i     (b1),
    .busy_o  (mul_busy[1]),
    .mag_o   (mag1),
    .neg_o   (mul_neg[1])
  );

  wpid_smul u_mul_deriv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (a2),
    .b_i     (b2),
    .busy_o  (mul_busy[2]),
    .mag_o   (mag2),
    .neg_o   (mul_neg[2])
  );

  wpid_sdiv u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag2[wpid_pkg::GD_W-1:0], {wpid_pkg::FRAC_W{1'b0}}}),
    .divisor_i  (step_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  //--------------------------------------------------------------------------
  // Window update
  //--------------------------------------------------------------------------
  assign slot = (head_q == wpid_pkg::HEAD_W'(wpid_pkg::WINDOW_LEN - 1))
              ? '0 : head_q + wpid_pkg::HEAD_W'(1);

  assign prod_mag = mag0[wpid_pkg::PROD_W-2:0];
  assign prod     = mul_neg[0] ? (~{1'b0, prod_mag} + wpid_pkg::PROD_W'(1)) : {1'b0, prod_mag};
  // an entry never written reads as zero
  assign evict    = win_valid_q[slot] ? ram_rdata : '0;

  wpid_ram #(
    .WIDTH (wpid_pkg::PROD_W),
    .DEPTH (wpid_pkg::WINDOW_LEN)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (area_upd),
    .waddr_i (slot),
    .wdata_i (prod),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      win_valid_q <= '0;
      area_q      <= '0;
      prev_err_q  <= '0;
    end else begin
      if (in_fire) begin
        prev_err_q <= in_data_i.error_value;
      end
      if (area_upd) begin
        head_q            <= slot;
        win_valid_q[slot] <= 1'b1;
        area_q <= area_q
                - {{(wpid_pkg::AREA_W-wpid_pkg::PROD_W){evict[wpid_pkg::PROD_W-1]}}, evict}
                + {{(wpid_pkg::AREA_W-wpid_pkg::PROD_W){prod[wpid_pkg::PROD_W-1]}}, prod};
      end
    end
  end

  //--------------------------------------------------------------------------
  // Terms and saturated sum
  //--------------------------------------------------------------------------
  assign zero_step = (step_q == '0);

  assign p_mag  = mag1[wpid_pkg::DRIVE_W-2:0];
  // truncate toward zero: shift the magnitude, then apply the sign
  assign i_ext  = wpid_pkg::SUM_W'(mag0[wpid_pkg::MP_W-1:wpid_pkg::FRAC_W]);
  assign i_term = mul_neg[0] ? (~i_ext + wpid_pkg::SUM_W'(1)) : i_ext;
  assign d_ext  = wpid_pkg::SUM_W'(quot);
  assign d_term = zero_step ? '0 : (mul_neg[2] ? (~d_ext + wpid_pkg::SUM_W'(1)) : d_ext);

  assign sum_hi   = sum_q[wpid_pkg::SUM_W-1:wpid_pkg::DRIVE_W-1];
  assign sum_fits = (&sum_hi) | ~(|sum_hi);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      step_q <= in_data_i.delta_time;
    end
    if (area_upd) begin
      p_q <= mul_neg[1] ? (~{1'b0, p_mag} + wpid_pkg::DRIVE_W'(1)) : {1'b0, p_mag};
    end
    if (sum_pi) begin
      sum_q <= {{(wpid_pkg::SUM_W-wpid_pkg::DRIVE_W){p_q[wpid_pkg::DRIVE_W-1]}}, p_q} + i_term;
    end else if (sum_d) begin
      sum_q <= sum_q + d_term;
    end
    if (out_load) begin
      out_q.drive_value <= sum_fits ? sum_q[wpid_pkg::DRIVE_W-1:0]
                         : (sum_q[wpid_pkg::SUM_W-1] ? wpid_pkg::DRIVE_MIN : wpid_pkg::DRIVE_MAX);
      out_q.saturated   <= ~sum_fits;
      out_q.zero_step   <= zero_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a new beat must find every serial unit at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> mul_busy == 3'b000 && !div_busy)
    else $error("input beat accepted while an arithmetic unit is busy");

  // the divider never runs on a zero step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> step_q != '0)
    else $error("divider started with a zero divisor");

  // a finished result reaches an empty output register on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wpid_pkg::ST_DONE && !out_valid_q |=> out_valid_q)
    else $error("result not moved into the output register");

  // the window is written only once the multipliers have settled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    area_upd |-> mul_busy == 3'b000)
    else $error("window written while a product is still forming");
`endif

endmodule
